>>> design/rgb_box_smooth_3x3_macros.svh
// assertion macros used by the smoothing filter rtl
`ifndef RGB_BOX_SMOOTH_3X3_MACROS_SVH
`define RGB_BOX_SMOOTH_3X3_MACROS_SVH

// same-cycle implication, checked on every rising edge out of reset
`define RBS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rbs check failed");

// next-cycle implication
`define RBS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rbs check failed");

`endif

>>> design/rbs_pkg.sv
// shared types, constants and reciprocal table for the 3x3 rgb smoothing filter
`timescale 1ns / 1ps
`default_nettype none

package rbs_pkg;

  localparam int MAX_SIDE_DEF     = 512;
  localparam int CHANNEL_BITS_DEF = 16;

  localparam int POS_W      = 9;
  localparam int SIZE_W     = 10;
  localparam int SIZE_RESET = 32;

  localparam int          APB_ADDR_W     = 3;
  localparam logic [0:0]  REG_IMAGE_SIZE = 1'b0;

  // quotient = (sum * recip) >> DIV_SHIFT, exact for sums below 2**20
  localparam int DIV_SHIFT = 24;
  localparam int RECIP_W   = 23;
  localparam logic [RECIP_W-1:0] RECIP_4 = RECIP_W'(1 << (DIV_SHIFT - 2));
  localparam logic [RECIP_W-1:0] RECIP_6 = RECIP_W'(((1 << DIV_SHIFT) + 5) / 6);
  localparam logic [RECIP_W-1:0] RECIP_9 = RECIP_W'(((1 << DIV_SHIFT) + 8) / 9);

  typedef enum logic [1:0] {
    DIV4 = 2'd0,
    DIV6 = 2'd1,
    DIV9 = 2'd2
  } div_kind_e;

  // one result to produce from the current window
  typedef struct packed {
    logic             rlo;   // drop the top window row
    logic             clo;   // drop the oldest window column
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             last;
  } job_t;

  function automatic logic [RECIP_W-1:0] recip_of(input div_kind_e kind);
    logic [RECIP_W-1:0] r;
    unique case (kind)
      DIV4:    r = RECIP_4;
      DIV6:    r = RECIP_6;
      DIV9:    r = RECIP_9;
      default: r = RECIP_9;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

>>> design/rgb_box_smooth_3x3.sv
// 3x3 box smoothing filter over a square rgb image, streaming in and out
//
// Pixels enter in raster order on the s_axis channel, one per beat, red in the
// low bits of tdata. Results leave on the m_axis channel: the three channel
// means plus the row and column they belong to; tlast marks the final result
// caused by one input pixel. Pixels in row 0, or in column 0 below it, cause
// no result; the last row produces two results per pixel and the last pixel
// of a frame produces four, so the frame is flushed without extra input.
// The side length is set through the apb register image_size (address 0);
// writing it starts a new frame, and it must only be written while idle.
// The first result of a pixel passes the registered stages a, b, c and d
// before it shows on m_axis; further results of the same pixel follow in
// order. Throughput: one pixel per cycle while each pixel yields at most one
// result and m_axis_tready stays high; a pixel yielding more results holds
// the input, as the result sequencer issues at most one result per cycle.
// Reset empties the pipeline, clears the window and the row and column
// counters and sets image_size to 32; the line store needs no clearing.
// When m_axis_tready is low the output stage holds, the stages behind it fill
// and s_axis_tready drops; nothing is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none
`include "rgb_box_smooth_3x3_macros.svh"

module rgb_box_smooth_3x3 import rbs_pkg::*; #(
  parameter int MAX_SIDE     = MAX_SIDE_DEF,
  parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // apb configuration port
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [31:0]           pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  // pixel input
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // red_in, green_in, blue_in from bit 0 up, zero padded to bytes
  input  wire logic [((3*CHANNEL_BITS+7)/8)*8-1:0] s_axis_tdata,
  // result output
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // red_out, green_out, blue_out, out_row, out_col from bit 0 up, zero padded
  output logic [((3*CHANNEL_BITS+2*POS_W+7)/8)*8-1:0] m_axis_tdata,
  output logic                       m_axis_tlast   // run_last
);

  localparam int PIX_W    = 3 * CHANNEL_BITS;
  localparam int CNT_W    = $clog2(MAX_SIDE);
  localparam int SIDE_RST = (SIZE_RESET > MAX_SIDE) ? MAX_SIDE : SIZE_RESET;
  localparam logic [CNT_W-1:0] LAST_RST = CNT_W'(SIDE_RST - 1);

  // ---------------- configuration ----------------
  logic              cfg_wr;
  logic [SIZE_W-1:0] new_size;
  logic [CNT_W-1:0]  new_last;
  logic [SIZE_W-1:0] image_size_q;
  logic [CNT_W-1:0]  side_last_q;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready && (paddr[2:2] == REG_IMAGE_SIZE);
  assign new_size = pwdata[SIZE_W-1:0];
  assign prdata   = (paddr[2:2] == REG_IMAGE_SIZE) ? 32'(image_size_q) : '0;

  always_comb begin
    if (new_size < 2) begin
      new_last = CNT_W'(1);
    end else if (new_size > MAX_SIDE) begin
      new_last = CNT_W'(MAX_SIDE - 1);
    end else begin
      new_last = CNT_W'(new_size - SIZE_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_size_q <= SIZE_W'(SIZE_RESET);
      side_last_q  <= LAST_RST;
    end else if (cfg_wr) begin
      image_size_q <= new_size;
      side_last_q  <= new_last;
    end
  end

  // ---------------- input beat and raster position ----------------
  logic             s_accept;
  logic [CNT_W-1:0] row_q, col_q;
  logic [3:0]       emit_mask;

  assign s_accept = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else if (cfg_wr) begin
      row_q <= '0;
      col_q <= '0;
    end else if (s_accept) begin
      if (col_q == side_last_q) begin
        col_q <= '0;
        row_q <= (row_q == side_last_q) ? '0 : row_q + CNT_W'(1);
      end else begin
        col_q <= col_q + CNT_W'(1);
      end
    end
  end

  // bit order follows raster order of the results
  assign emit_mask = {
    (row_q == side_last_q) && (col_q == side_last_q),
    (row_q == side_last_q) && (col_q != '0),
    (row_q != '0) && (col_q == side_last_q),
    (row_q != '0) && (col_q != '0)
  };

  // ---------------- stage a: line store read ----------------
  logic                   a_valid_q;
  logic [PIX_W-1:0]       a_px_q;
  logic [CNT_W-1:0]       a_col_q;
  logic [3:0]             a_mask_q;
  logic                   a_rlo_q, a_clo_q;
  logic [POS_W-1:0]       a_row_pos_q, a_col_pos_q;
  logic                   a_move;

  // entry holds {row above, two rows above}
  logic [2*PIX_W-1:0] line_mem [MAX_SIDE];
  logic [2*PIX_W-1:0] rd_q;
  logic [PIX_W-1:0]   rd_one_up, rd_two_up;

  assign rd_two_up = rd_q[PIX_W-1:0];
  assign rd_one_up = rd_q[2*PIX_W-1:PIX_W];

  assign s_axis_tready = !a_valid_q || a_move;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (s_accept) begin
      a_valid_q <= 1'b1;
    end else if (a_move) begin
      a_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      a_px_q      <= s_axis_tdata[PIX_W-1:0];
      a_col_q     <= col_q;
      a_mask_q    <= emit_mask;
      a_rlo_q     <= row_q < 2;
      a_clo_q     <= col_q < 2;
      a_row_pos_q <= POS_W'(row_q);
      a_col_pos_q <= POS_W'(col_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_move) begin
      line_mem[a_col_q] <= {a_px_q, rd_one_up};
    end
    if (s_accept) begin
      rd_q <= line_mem[col_q];
    end
  end

  // ---------------- stage b: window and result sequencer ----------------
  logic [2:0][CHANNEL_BITS-1:0] win_q [3][3];
  logic [3:0]       b_mask_q;
  logic             b_rlo_q, b_clo_q;
  logic [POS_W-1:0] b_row_q, b_col_q;
  logic [3:0]       sel;
  logic [3:0]       rest;
  logic             b_any, b_free, c_take, mean_ready;
  job_t             job;

  always_comb begin
    if (b_mask_q[0]) begin
      sel = 4'b0001;
    end else if (b_mask_q[1]) begin
      sel = 4'b0010;
    end else if (b_mask_q[2]) begin
      sel = 4'b0100;
    end else begin
      sel = {b_mask_q[3], 3'b000};
    end
  end

  assign rest   = b_mask_q & ~sel;
  assign b_any  = |b_mask_q;
  assign c_take = b_any && mean_ready;
  assign b_free = !b_any || (rest == '0 && mean_ready);
  assign a_move = a_valid_q && b_free;

  always_comb begin
    job.rlo  = b_rlo_q;
    job.clo  = b_clo_q;
    job.row  = b_row_q - POS_W'(1);
    job.col  = b_col_q - POS_W'(1);
    job.last = (rest == '0);
    if (sel[1]) begin
      job.clo = 1'b1;
      job.col = b_col_q;
    end
    if (sel[2]) begin
      job.rlo = 1'b1;
      job.row = b_row_q;
    end
    if (sel[3]) begin
      job.rlo = 1'b1;
      job.clo = 1'b1;
      job.row = b_row_q;
      job.col = b_col_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_mask_q <= '0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win_q[i][j] <= '0;
        end
      end
    end else begin
      if (a_move) begin
        b_mask_q <= a_mask_q;
        for (int i = 0; i < 3; i++) begin
          win_q[i][0] <= win_q[i][1];
          win_q[i][1] <= win_q[i][2];
        end
        win_q[0][2] <= rd_two_up;
        win_q[1][2] <= rd_one_up;
        win_q[2][2] <= a_px_q;
      end else if (c_take) begin
        b_mask_q <= rest;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_move) begin
      b_rlo_q <= a_rlo_q;
      b_clo_q <= a_clo_q;
      b_row_q <= a_row_pos_q;
      b_col_q <= a_col_pos_q;
    end
  end

  // ---------------- stages c and d: sum, divide, output ----------------
  logic [CHANNEL_BITS-1:0] out_red, out_green, out_blue;
  logic [POS_W-1:0]        out_row, out_col;

  rbs_mean #(
    .CHANNEL_BITS (CHANNEL_BITS)
  ) u_mean (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (b_any),
    .in_ready_o  (mean_ready),
    .win_i       (win_q),
    .job_i       (job),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_red_o   (out_red),
    .out_green_o (out_green),
    .out_blue_o  (out_blue),
    .out_row_o   (out_row),
    .out_col_o   (out_col),
    .out_last_o  (m_axis_tlast)
  );

  always_comb begin
    m_axis_tdata = '0;
    m_axis_tdata[PIX_W+2*POS_W-1:0] = {out_col, out_row, out_blue, out_green, out_red};
  end

  // ---------------- checks ----------------
  `RBS_ASSERT_IMPL(a_no_line_clash, a_move && s_accept, a_col_q != col_q)
  `RBS_ASSERT_IMPL(a_pos_in_range, 1'b1, row_q <= side_last_q && col_q <= side_last_q)
  `RBS_ASSERT_NEXT(a_win_load, a_move, win_q[2][2] == $past(a_px_q))
  `RBS_ASSERT_IMPL(a_hold_while_busy, a_valid_q && !b_free, !s_axis_tready)

endmodule

`default_nettype wire

>>> design/rbs_mean.sv
// neighbourhood sum and reciprocal divide, two registered stages with backpressure
`timescale 1ns / 1ps
`default_nettype none

module rbs_mean import rbs_pkg::*; #(
  parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [2:0][CHANNEL_BITS-1:0]  win_i [3][3],
  input  wire job_t                          job_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [CHANNEL_BITS-1:0]            out_red_o,
  output logic [CHANNEL_BITS-1:0]            out_green_o,
  output logic [CHANNEL_BITS-1:0]            out_blue_o,
  output logic [POS_W-1:0]                   out_row_o,
  output logic [POS_W-1:0]                   out_col_o,
  output logic                               out_last_o
);

  localparam int SUM_W  = CHANNEL_BITS + 4;
  localparam int PROD_W = SUM_W + RECIP_W;

  logic [2:0][SUM_W-1:0] sum;
  div_kind_e             kind;

  logic                  c_valid_q;
  logic [2:0][SUM_W-1:0] c_sum_q;
  div_kind_e             c_kind_q;
  logic [POS_W-1:0]      c_row_q, c_col_q;
  logic                  c_last_q;

  logic                   d_valid_q;
  logic [2:0][PROD_W-1:0] d_prod_q;
  logic [POS_W-1:0]       d_row_q, d_col_q;
  logic                   d_last_q;

  logic c_ready, d_ready;

  assign d_ready    = !d_valid_q || out_ready_i;
  assign c_ready    = !c_valid_q || d_ready;
  assign in_ready_o = c_ready;

  always_comb begin
    sum = '0;
    for (int ch = 0; ch < 3; ch++) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          if ((i != 0 || !job_i.rlo) && (j != 0 || !job_i.clo)) begin
            sum[ch] = sum[ch] + SUM_W'(win_i[i][j][ch]);
          end
        end
      end
    end
  end

  always_comb begin
    if (job_i.rlo && job_i.clo) begin
      kind = DIV4;
    end else if (job_i.rlo || job_i.clo) begin
      kind = DIV6;
    end else begin
      kind = DIV9;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
      d_valid_q <= 1'b0;
    end else begin
      if (c_ready) begin
        c_valid_q <= in_valid_i;
      end
      if (d_ready) begin
        d_valid_q <= c_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (c_ready && in_valid_i) begin
      c_sum_q  <= sum;
      c_kind_q <= kind;
      c_row_q  <= job_i.row;
      c_col_q  <= job_i.col;
      c_last_q <= job_i.last;
    end
    if (d_ready && c_valid_q) begin
      for (int ch = 0; ch < 3; ch++) begin
        d_prod_q[ch] <= PROD_W'(c_sum_q[ch]) * PROD_W'(recip_of(c_kind_q));
      end
      d_row_q  <= c_row_q;
      d_col_q  <= c_col_q;
      d_last_q <= c_last_q;
    end
  end

  assign out_valid_o = d_valid_q;
  assign out_red_o   = d_prod_q[0][DIV_SHIFT +: CHANNEL_BITS];
  assign out_green_o = d_prod_q[1][DIV_SHIFT +: CHANNEL_BITS];
  assign out_blue_o  = d_prod_q[2][DIV_SHIFT +: CHANNEL_BITS];
  assign out_row_o   = d_row_q;
  assign out_col_o   = d_col_q;
  assign out_last_o  = d_last_q;

endmodule

`default_nettype wire
